// File: design/gha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the GHASH accumulator.
// ---------------------------------------------------------------------------
package gha_pkg;

    localparam int GHA_BLOCK_W  = 128;
    localparam int GHA_HALF_W   = 64;
    localparam int GHA_DIGIT_W  = 8;
    localparam int GHA_STEPS    = GHA_BLOCK_W / GHA_DIGIT_W;
    localparam int GHA_CNT_W    = $clog2(GHA_STEPS);
    localparam int GHA_NBYTES_W = 5;
    localparam int GHA_IN_W     = 136;

    // Reduction constant, folded into the top byte after a right shift that drops a set bit
    localparam logic [7:0] GHA_REDUCE = 8'hE1;

    // Configuration register indexes
    localparam logic GHA_REG_SUBKEY_HIGH = 1'b0;
    localparam logic GHA_REG_SUBKEY_LOW  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_gha_state;

    typedef struct packed {
        logic load;
    } t_gha_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gha_stat;

endpackage : gha_pkg
`default_nettype wire

// File: design/ghash_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH: pad block, fold into accumulator, multiply by H in GF(2^128).
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: data_high, data_low, valid_bytes; tuser: first_block
// m_axis    out        tdata: hash_high, hash_low
// cfg       in         index 0 subkey_high, index 1 subkey_low
//
// A block runs as 16 multiplier digits of eight bits each; then the product
// is retired and the input reopens. The next block needs the finished
// accumulator.
// Reset clears the accumulator, subkey, control and output valid.
// A stalled output holds its result while the next block is taken and run;
// only a second finished result waits for the output register to drain.
// ---------------------------------------------------------------------------
module ghash_accumulator
    import gha_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [GHA_HALF_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [GHA_IN_W-1:0]   s_axis_tdata,   // data_high, data_low, valid_bytes
    input  wire logic                  s_axis_tuser,   // first_block
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [GHA_BLOCK_W-1:0]     m_axis_tdata    // hash_high, hash_low
);

    t_gha_state r_state, n_state;

    logic [GHA_HALF_W-1:0]  r_subkey_high;
    logic [GHA_HALF_W-1:0]  r_subkey_low;
    logic [GHA_BLOCK_W-1:0] r_acc;
    logic [GHA_BLOCK_W-1:0] r_out;
    logic                   r_out_valid;

    logic [GHA_BLOCK_W-1:0] w_x;
    logic [GHA_BLOCK_W-1:0] w_z;
    t_gha_ctrl              w_ctrl;
    t_gha_stat              w_stat;
    logic                   w_in_fire;
    logic                   w_out_free;
    logic                   w_acc_load;
    logic                   w_out_load_z;
    logic                   w_out_load_acc;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    gha_mask u_mask (
        .i_data_high   (s_axis_tdata[GHA_HALF_W-1:0]),
        .i_data_low    (s_axis_tdata[GHA_BLOCK_W-1:GHA_HALF_W]),
        .i_valid_bytes (s_axis_tdata[GHA_BLOCK_W+GHA_NBYTES_W-1:GHA_BLOCK_W]),
        .i_first_block (s_axis_tuser),
        .i_acc         (r_acc),
        .o_x           (w_x)
    );

    gha_mul_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_x     (w_x),
        .i_h     ({r_subkey_high, r_subkey_low}),
        .o_stat  (w_stat),
        .o_z     (w_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        s_axis_tready  = 1'b0;
        w_ctrl.load    = 1'b0;
        w_acc_load     = 1'b0;
        w_out_load_z   = 1'b0;
        w_out_load_acc = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    w_ctrl.load = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                if (w_stat.done) begin
                    w_acc_load = 1'b1;
                    if (w_out_free) begin
                        w_out_load_z = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_out_load_acc = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration writes; index range covers both registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subkey_high <= '0;
            r_subkey_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                GHA_REG_SUBKEY_HIGH: r_subkey_high <= i_cfg_data;
                GHA_REG_SUBKEY_LOW:  r_subkey_low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_acc_load) begin
            r_acc <= w_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load_z || w_out_load_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load_z) begin
            r_out <= w_z;
        end else if (w_out_load_acc) begin
            r_out <= r_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[GHA_HALF_W-1:0], r_out[GHA_BLOCK_W-1:GHA_HALF_W]};

endmodule : ghash_accumulator
`default_nettype wire

// File: design/gha_mask.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gha_mask
// Pads a partial block with zeros and folds it into the accumulator, except on a first block.
// ---------------------------------------------------------------------------
module gha_mask
    import gha_pkg::*;
(
    input  wire logic [GHA_HALF_W-1:0]   i_data_high,
    input  wire logic [GHA_HALF_W-1:0]   i_data_low,
    input  wire logic [GHA_NBYTES_W-1:0] i_valid_bytes,
    input  wire logic                    i_first_block,
    input  wire logic [GHA_BLOCK_W-1:0]  i_acc,
    output logic      [GHA_BLOCK_W-1:0]  o_x
);

    logic [GHA_BLOCK_W-1:0] w_block;
    logic [GHA_BLOCK_W-1:0] w_padded;

    assign w_block = {i_data_high, i_data_low};

    // Keep byte i only while it lies below the count; counts above 16 keep all
    always_comb begin
        for (int i = 0; i < GHA_BLOCK_W / 8; i++) begin
            if (GHA_NBYTES_W'(i) < i_valid_bytes) begin
                w_padded[GHA_BLOCK_W-1-8*i -: 8] = w_block[GHA_BLOCK_W-1-8*i -: 8];
            end else begin
                w_padded[GHA_BLOCK_W-1-8*i -: 8] = 8'h00;
            end
        end
    end

    assign o_x = w_padded ^ (i_first_block ? '0 : i_acc);

endmodule : gha_mask
`default_nettype wire

// File: design/gha_mul_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gha_mul_core
// Digit-serial GF(2^128) multiplier, eight multiplier bits per cycle.
// ---------------------------------------------------------------------------
module gha_mul_core
    import gha_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_gha_ctrl              i_ctrl,
    input  wire logic [GHA_BLOCK_W-1:0] i_x,
    input  wire logic [GHA_BLOCK_W-1:0] i_h,
    output t_gha_stat                   o_stat,
    output logic      [GHA_BLOCK_W-1:0] o_z
);

    logic [GHA_BLOCK_W-1:0] r_x, n_x;
    logic [GHA_BLOCK_W-1:0] r_v, n_v;
    logic [GHA_BLOCK_W-1:0] r_z, n_z;
    logic [GHA_CNT_W-1:0]   r_cnt;
    logic                   r_busy;
    logic                   r_done;

    // One digit: walk the top eight bits of X, shifting V right each bit
    always_comb begin
        logic [GHA_BLOCK_W-1:0] v;
        logic [GHA_BLOCK_W-1:0] z;
        logic                   lsb;
        v = r_v;
        z = r_z;
        for (int k = 0; k < GHA_DIGIT_W; k++) begin
            if (r_x[GHA_BLOCK_W-1-k]) begin
                z = z ^ v;
            end
            lsb = v[0];
            v   = v >> 1;
            if (lsb) begin
                v[GHA_BLOCK_W-1 -: 8] = v[GHA_BLOCK_W-1 -: 8] ^ GHA_REDUCE;
            end
        end
        n_v = v;
        n_z = z;
        n_x = r_x << GHA_DIGIT_W;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
            r_v <= i_h;
            r_z <= '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_v <= n_v;
            r_z <= n_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.load) begin
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == GHA_CNT_W'(GHA_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_z         = r_z;

endmodule : gha_mul_core
`default_nettype wire

// File: design/gha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gha_checker
// Port-level checks on the GHASH accumulator's streams.
// ---------------------------------------------------------------------------
module gha_checker
    import gha_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [GHA_BLOCK_W-1:0] m_axis_tdata
);

    // Hold the input closed while the multiplier runs
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after a transaction");

    a_busy_whole_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##16 !s_axis_tready)
        else $error("input reopened before the multiply finished");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("reset left output valid or input closed");

endmodule : gha_checker

bind ghash_accumulator gha_checker u_gha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: verif/tb_ghash_accumulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ghash_accumulator
// Self-checking bench for the GHASH accumulator. A queue of 16-byte blocks
// feeds a stream driver, and each accepted block updates a local GF(2^128)
// hash predictor. A monitor compares every returned hash with the oldest
// prediction. Runs cover a range of subkeys, padded and partial blocks, and
// random back-pressure, including one long output stall.
// ---------------------------------------------------------------------------
module tb_ghash_accumulator;
    import gha_pkg::*;

    typedef struct packed {
        logic                    first;
        logic [GHA_HALF_W-1:0]   dh;
        logic [GHA_HALF_W-1:0]   dl;
        logic [GHA_NBYTES_W-1:0] nbytes;
    } t_block;

    typedef struct packed {
        logic [GHA_HALF_W-1:0] hi;
        logic [GHA_HALF_W-1:0] lo;
    } t_hash;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = GHA_REG_SUBKEY_HIGH;
    logic [GHA_HALF_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [GHA_IN_W-1:0]   s_axis_tdata = '0;   // data_high, data_low, valid_bytes
    logic                  s_axis_tuser = 1'b0; // first_block
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [GHA_BLOCK_W-1:0] m_axis_tdata;       // hash_high, hash_low

    t_block                 block_q[$];
    t_hash                  hash_expect_q[$];
    t_block                 bus_block = '0;
    logic [GHA_BLOCK_W-1:0] acc_model = '0;
    logic [GHA_BLOCK_W-1:0] subkey_model = '0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     err_cnt = 0;
    logic                   hold_req = 1'b0;
    logic                   hold_done = 1'b0;
    int                     hold_left = 0;

    ghash_accumulator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // GCM bit order: x[127] is bit 0 of the field element
    function automatic logic [GHA_BLOCK_W-1:0] gf128_mult(input logic [GHA_BLOCK_W-1:0] x,
                                                          input logic [GHA_BLOCK_W-1:0] h);
        logic [GHA_BLOCK_W-1:0] z;
        logic [GHA_BLOCK_W-1:0] v;
        logic                   lsb;
        z = '0;
        v = h;
        for (int i = 0; i < GHA_BLOCK_W; i++) begin
            if (x[GHA_BLOCK_W-1-i])
                z ^= v;
            lsb = v[0];
            v = v >> 1;
            if (lsb)
                v[GHA_BLOCK_W-1 -: 8] ^= GHA_REDUCE;
        end
        return z;
    endfunction

    task automatic fold_block(input t_block b);
        logic [GHA_BLOCK_W-1:0] mask;
        int                     n;
        t_hash                  h;
        n = (b.nbytes > 16) ? 16 : int'(b.nbytes);
        mask = (n == 0) ? '0 : ({GHA_BLOCK_W{1'b1}} << (GHA_BLOCK_W - 8 * n));
        if (b.first)
            acc_model = '0;
        acc_model = gf128_mult(acc_model ^ ({b.dh, b.dl} & mask), subkey_model);
        h.hi = acc_model[GHA_BLOCK_W-1:GHA_HALF_W];
        h.lo = acc_model[GHA_HALF_W-1:0];
        hash_expect_q.push_back(h);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Sender: predict on each accepted transaction, then offer the next block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fold_block(bus_block);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (block_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_block b;
                    b = block_q.pop_front();
                    bus_block     <= b;
                    s_axis_tdata  <= {3'b000, b.nbytes, b.dl, b.dh};
                    s_axis_tuser  <= b.first;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready, with a single long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hash_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %h", m_axis_tdata));
            end else begin
                t_hash e;
                e = hash_expect_q.pop_front();
                if (m_axis_tdata[GHA_HALF_W-1:0] !== e.hi)
                    report_mismatch($sformatf("hash_high %h, want %h",
                                              m_axis_tdata[GHA_HALF_W-1:0], e.hi));
                if (m_axis_tdata[GHA_BLOCK_W-1:GHA_HALF_W] !== e.lo)
                    report_mismatch($sformatf("hash_low %h, want %h",
                                              m_axis_tdata[GHA_BLOCK_W-1:GHA_HALF_W], e.lo));
            end
        end
    end

    function automatic logic [GHA_HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_block mk_block(input logic first, input logic [GHA_HALF_W-1:0] dh,
                                        input logic [GHA_HALF_W-1:0] dl, input int nbytes);
        t_block b;
        b.first  = first;
        b.dh     = dh;
        b.dl     = dl;
        b.nbytes = GHA_NBYTES_W'(nbytes);
        return b;
    endfunction

    task automatic cfg_write(input logic idx, input logic [GHA_HALF_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == GHA_REG_SUBKEY_HIGH)
            subkey_model[GHA_BLOCK_W-1:GHA_HALF_W] = val;
        else
            subkey_model[GHA_HALF_W-1:0] = val;
    endtask

    task automatic set_subkey(input logic [GHA_HALF_W-1:0] hi, input logic [GHA_HALF_W-1:0] lo);
        cfg_write(GHA_REG_SUBKEY_HIGH, hi);
        cfg_write(GHA_REG_SUBKEY_LOW, lo);
    endtask

    // Wait until every queued block is sent and every predicted hash has returned
    task automatic wait_drained();
        while (block_q.size() != 0 || s_axis_tvalid || hash_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // Mostly whole messages: full blocks and a padded tail; some noise blocks
    task automatic queue_random(input int count);
        int nblk;
        int pushed;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 99) < 15) begin
                block_q.push_back(mk_block(1'($urandom_range(0, 1)), rand64(), rand64(),
                                           $urandom_range(0, 31)));
                pushed++;
            end else begin
                nblk = $urandom_range(1, 8);
                for (int k = 0; k < nblk; k++) begin
                    block_q.push_back(mk_block(k == 0, rand64(), rand64(),
                        (k == nblk - 1 && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 16));
                end
                pushed += nblk;
            end
        end
    endtask

    initial begin
        logic [GHA_HALF_W-1:0] ones;
        logic [GHA_HALF_W-1:0] msb;
        ones = '1;
        msb  = {1'b1, {(GHA_HALF_W-1){1'b0}}};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 56;

        // Reset subkey is zero: every hash must come back zero
        block_q.push_back(mk_block(1'b1, ones, ones, 16));
        block_q.push_back(mk_block(1'b0, rand64(), rand64(), 0));
        block_q.push_back(mk_block(1'b0, ones, ones, 31));
        wait_drained();

        set_subkey(rand64(), rand64());
        block_q.push_back(mk_block(1'b1, ones, ones, 16));
        block_q.push_back(mk_block(1'b0, ones, ones, 0));
        block_q.push_back(mk_block(1'b0, ones, ones, 1));
        block_q.push_back(mk_block(1'b0, ones, ones, 7));
        block_q.push_back(mk_block(1'b0, ones, ones, 8));
        block_q.push_back(mk_block(1'b0, ones, ones, 9));
        block_q.push_back(mk_block(1'b0, ones, ones, 15));
        block_q.push_back(mk_block(1'b0, ones, ones, 17));
        block_q.push_back(mk_block(1'b0, ones, ones, 31));
        block_q.push_back(mk_block(1'b1, '0, '0, 16));
        block_q.push_back(mk_block(1'b1, msb, '0, 16));
        block_q.push_back(mk_block(1'b0, '0, 64'h1, 16));
        block_q.push_back(mk_block(1'b1, rand64(), rand64(), 12));
        wait_drained();

        // Multiplicative identity, then an all-ones subkey
        set_subkey(msb, '0);
        block_q.push_back(mk_block(1'b1, rand64(), rand64(), 16));
        block_q.push_back(mk_block(1'b0, rand64(), rand64(), 5));
        block_q.push_back(mk_block(1'b0, ones, ones, 16));
        wait_drained();
        set_subkey(ones, ones);
        block_q.push_back(mk_block(1'b1, ones, ones, 16));
        block_q.push_back(mk_block(1'b0, rand64(), rand64(), 16));
        block_q.push_back(mk_block(1'b0, rand64(), rand64(), 11));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0, 2:    set_subkey(rand64(), rand64());
                1:       set_subkey('0, 64'h1);
                3:       set_subkey(ones, ones);
                default: set_subkey(rand64(), rand64());
            endcase
            case (ph / 2)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            queue_random(235);
            // Stall the output long enough for the input to back up
            if (ph == 4) begin
                @(posedge i_clk);
                hold_req <= 1'b1;
            end
            wait_drained();
        end

        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
